[src/nsc_pkg.sv]
// Package for the NMEA sentence classifier: payload structs, phase and kind codes,
// the table of known sentence tags and the hex digit decoder.
// Depends on nothing; every other file in src uses it by scoped names.
package nsc_pkg;

    localparam int unsigned TAG_LEN   = 5;
    localparam int unsigned TAG_COUNT = 8;
    localparam int unsigned POS_W     = $clog2(TAG_LEN + 1);

    localparam logic [7:0] STAR_CHAR = 8'h2A;
    localparam logic [7:0] HEX_BASE  = 8'd16;

    // Result kind codes.
    localparam logic [3:0] KIND_UNKNOWN  = 4'd0;
    localparam logic [3:0] KIND_CSUM_ERR = 4'd1;
    localparam logic [3:0] KIND_TAG_BASE = 4'd2;

    typedef struct packed {
        logic [7:0] byte_req;
        logic       last;
    } t_in;

    typedef struct packed {
        logic [3:0] sentence_kind;
        logic [7:0] computed_sum;
        logic [7:0] received_sum;
    } t_out;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_BODY  = 2'd1,
        PH_HEX   = 2'd2,
        PH_TAIL  = 2'd3
    } t_phase;

    // Known tags, bit k of the match mask belongs to row k.
    localparam logic [7:0] TAG_TABLE [TAG_COUNT][TAG_LEN] = '{
        '{"G", "P", "G", "G", "A"},
        '{"G", "P", "R", "M", "C"},
        '{"G", "P", "G", "S", "A"},
        '{"G", "P", "Z", "D", "A"},
        '{"G", "P", "V", "T", "G"},
        '{"G", "P", "G", "S", "V"},
        '{"G", "P", "G", "L", "L"},
        '{"G", "P", "T", "X", "T"}
    };

    // Returns {is_digit, value}; value is zero when the byte is not a hex digit.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] res;
        res = 5'd0;
        if (c inside {["0":"9"]}) begin
            res = {1'b1, 4'(c - 8'h30)};
        end else if (c inside {["A":"F"]}) begin
            res = {1'b1, 4'(c - 8'h37)};
        end else if (c inside {["a":"f"]}) begin
            res = {1'b1, 4'(c - 8'h57)};
        end
        return res;
    endfunction

endpackage

[src/nsc_sentence_core.sv]
// Per-sentence state of the NMEA classifier: running XOR, hex checksum,
// tag matching and the kind decision on the last byte. Uses nsc_pkg.
module nsc_sentence_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  nsc_pkg::t_in  i_item,
    output logic          o_result_valid,
    output nsc_pkg::t_out o_result
);

    nsc_pkg::t_phase               r_phase, n_phase;
    logic [7:0]                    r_xor, n_xor;
    logic [7:0]                    r_hex, n_hex;
    logic [nsc_pkg::POS_W-1:0]     r_tag_pos, n_tag_pos;
    logic [nsc_pkg::TAG_COUNT-1:0] r_mask, n_mask;
    logic                          r_star, n_star;

    logic [4:0] w_digit;
    logic [3:0] w_kind;
    logic [7:0] w_c;

    assign w_c     = i_item.byte_req;
    assign w_digit = nsc_pkg::hex_decode(w_c);

    always_comb begin
        n_phase   = r_phase;
        n_xor     = r_xor;
        n_hex     = r_hex;
        n_tag_pos = r_tag_pos;
        n_mask    = r_mask;
        n_star    = r_star;
        case (r_phase)
            nsc_pkg::PH_START: begin
                n_phase = nsc_pkg::PH_BODY;
            end
            nsc_pkg::PH_BODY: begin
                if (w_c == nsc_pkg::STAR_CHAR) begin
                    n_star  = 1'b1;
                    n_phase = nsc_pkg::PH_HEX;
                end else begin
                    n_xor = r_xor ^ w_c;
                    if (r_tag_pos < nsc_pkg::POS_W'(nsc_pkg::TAG_LEN)) begin
                        for (int k = 0; k < nsc_pkg::TAG_COUNT; k++) begin
                            if (nsc_pkg::TAG_TABLE[k][r_tag_pos] != w_c) begin
                                n_mask[k] = 1'b0;
                            end
                        end
                        n_tag_pos = r_tag_pos + 1'b1;
                    end
                end
            end
            nsc_pkg::PH_HEX: begin
                if (w_digit[4]) begin
                    // Multiply by the base as a shift, keep the low byte.
                    n_hex = {r_hex[3:0], w_digit[3:0]};
                end else begin
                    n_phase = nsc_pkg::PH_TAIL;
                end
            end
            default: begin
            end
        endcase
    end

    // Kind decision uses the state as it stands after this byte.
    always_comb begin
        w_kind = nsc_pkg::KIND_UNKNOWN;
        if (n_star) begin
            if (n_xor != n_hex) begin
                w_kind = nsc_pkg::KIND_CSUM_ERR;
            end else if (n_tag_pos >= nsc_pkg::POS_W'(nsc_pkg::TAG_LEN)) begin
                for (int k = nsc_pkg::TAG_COUNT - 1; k >= 0; k--) begin
                    if (n_mask[k]) begin
                        w_kind = nsc_pkg::KIND_TAG_BASE + 4'(k);
                    end
                end
            end
        end
    end

    assign o_result_valid         = i_step && i_item.last;
    assign o_result.sentence_kind = w_kind;
    assign o_result.computed_sum  = n_xor;
    assign o_result.received_sum  = n_star ? n_hex : 8'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.last)) begin
            r_phase   <= nsc_pkg::PH_START;
            r_xor     <= '0;
            r_hex     <= '0;
            r_tag_pos <= '0;
            r_mask    <= '1;
            r_star    <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_xor     <= n_xor;
            r_hex     <= n_hex;
            r_tag_pos <= n_tag_pos;
            r_mask    <= n_mask;
            r_star    <= n_star;
        end
    end

    a_star_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_star == ((r_phase == nsc_pkg::PH_HEX) || (r_phase == nsc_pkg::PH_TAIL)))
        else $error("star flag disagrees with phase");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tag_pos <= nsc_pkg::POS_W'(nsc_pkg::TAG_LEN))
        else $error("tag position ran past the tag length");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.last) |=> (r_phase == nsc_pkg::PH_START) && (r_mask == '1))
        else $error("sentence state not cleared after last byte");

endmodule

[src/nmea_sentence_classifier.sv]
// Top level of the NMEA 0183 sentence classifier: input register, sentence core,
// result register and the valid/ready handshakes. Uses nsc_pkg and nsc_sentence_core.
//
// The block takes an NMEA sentence one byte per request, with a last flag on the
// final byte, and returns one result per sentence when that last byte has been
// processed. The first byte is taken as the start mark and skipped; each later
// byte up to the first asterisk is XORed into the computed checksum, and the hex
// digits after the asterisk (either case) give the received checksum, low byte
// kept. The kind is unknown without an asterisk, checksum error when the two sums
// differ, and otherwise one of eight GP sentence types when the five bytes after
// the start mark spell its tag, else unknown. Throughout is one byte per clock
// while the consumer does not stall: a request is held in the input register,
// the sentence core updates its state in the cycle the held byte moves on, and
// the result is registered in the output register, from which it is offered.
// The output register holds a result while the consumer stalls; the input
// register then fills and ready drops only when both stages are occupied.
module nmea_sentence_classifier (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  nsc_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output nsc_pkg::t_out o_out_data
);

    logic          r_in_valid;
    nsc_pkg::t_in  r_in;
    logic          r_out_valid;
    nsc_pkg::t_out r_out;

    logic          w_consume;
    logic          w_res_valid;
    nsc_pkg::t_out w_res;

    // The held byte moves into the core whenever the result register can take
    // whatever it might produce.
    assign w_consume  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    nsc_sentence_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_consume),
        .i_item         (r_in),
        .o_result_valid (w_res_valid),
        .o_result       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_consume) |=> r_in_valid)
        else $error("held request lost without being consumed");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_consume && r_in.last))
        else $error("result appeared without a last byte");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten while stalled");

endmodule

[bench/nmea_sentence_classifier_tb.sv]
// Self-checking testbench for nmea_sentence_classifier: a directed table of requests,
// then random NMEA sentences, checked against typed-in results or a cycle-free model.
// Depends on nsc_pkg for the payload structs, kind codes, phase enum and tag table.
`timescale 1ns / 100ps

module nmea_sentence_classifier_tb;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_PAD    = 10;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned RANDOM_ITEMS = 500;
    localparam int unsigned DIR_ROWS     = 26;

    // One row of the directed table. When typed_in is set the expected result of a
    // last byte is written out in the row; otherwise the sentence model supplies it.
    typedef struct {
        logic [7:0]    ch;
        logic          lst;
        bit            typed_in;
        nsc_pkg::t_out want;
    } t_dir_row;

    // All block inputs start at known values.
    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          in_valid  = 1'b0;
    nsc_pkg::t_in  in_data   = '0;
    logic          out_ready = 1'b0;
    logic          in_ready;
    logic          out_valid;
    nsc_pkg::t_out out_data;

    // Expected classifications, oldest first.
    nsc_pkg::t_out expected_kinds_q [$];
    int unsigned   fail_count = 0;
    int unsigned   cycle_count = 0;
    int unsigned   random_items = 0;

    // Knobs shared between the stimulus thread and the consumer process.
    bit src_calm     = 1'b0;
    bit sink_calm    = 1'b0;
    bit hold_pending = 1'b0;

    t_dir_row dir_rows [DIR_ROWS];

    // State of the sentence model, kept at the block's widths.
    nsc_pkg::t_phase           sm_phase;
    logic [7:0]                sm_xor;
    logic [7:0]                sm_hex;
    logic [nsc_pkg::POS_W-1:0] sm_pos;
    logic [7:0]                sm_mask;
    logic                      sm_star;

    nmea_sentence_classifier uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The run is bounded by a free-running cycle counter; hitting the limit means
    // the block stopped accepting requests or stopped producing results.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("nmea_sentence_classifier regression: fail");
            $finish;
        end
    end

    // Brings the sentence model back to its idle state, as after each result.
    function automatic void sentence_clear();
        sm_phase = nsc_pkg::PH_START;
        sm_xor   = 8'h00;
        sm_hex   = 8'h00;
        sm_pos   = '0;
        sm_mask  = 8'hFF;
        sm_star  = 1'b0;
    endfunction

    // Advances the sentence model by one accepted byte. Returns 1 and fills res when
    // the byte is flagged last, since only then does the block produce a result.
    function automatic bit classify_byte(input logic [7:0] c, input logic lst,
                                         output nsc_pkg::t_out res);
        logic       is_digit;
        logic [3:0] nib;
        logic [7:0] folded;
        logic [3:0] kind;
        int         k;
        res = '0;
        is_digit = 1'b0;
        nib = 4'd0;
        folded = c | 8'h20;
        case (sm_phase)
            nsc_pkg::PH_START: begin
                // The start mark is skipped whatever its value.
                sm_phase = nsc_pkg::PH_BODY;
            end
            nsc_pkg::PH_BODY: begin
                if (c == nsc_pkg::STAR_CHAR) begin
                    sm_star  = 1'b1;
                    sm_phase = nsc_pkg::PH_HEX;
                end else begin
                    sm_xor ^= c;
                    if (sm_pos < nsc_pkg::TAG_LEN) begin
                        for (k = 0; k < nsc_pkg::TAG_COUNT; k++) begin
                            if (nsc_pkg::TAG_TABLE[k][sm_pos] != c) begin
                                sm_mask[k] = 1'b0;
                            end
                        end
                        sm_pos++;
                    end
                end
            end
            nsc_pkg::PH_HEX: begin
                // Folding bit 5 maps upper case hex letters onto lower case ones.
                if (c >= "0" && c <= "9") begin
                    is_digit = 1'b1;
                    nib = c[3:0];
                end else if (folded >= "a" && folded <= "f") begin
                    is_digit = 1'b1;
                    nib = c[3:0] + 4'd9;
                end
                if (is_digit) begin
                    sm_hex = {sm_hex[3:0], nib};
                end else begin
                    sm_phase = nsc_pkg::PH_TAIL;
                end
            end
            default: begin
                // Everything after the hex digits is ignored.
            end
        endcase

        if (!lst) begin
            return 1'b0;
        end

        kind = nsc_pkg::KIND_UNKNOWN;
        if (sm_star) begin
            if (sm_xor != sm_hex) begin
                kind = nsc_pkg::KIND_CSUM_ERR;
            end else if (sm_pos >= nsc_pkg::TAG_LEN) begin
                // Walk downward so the lowest matching tag wins.
                for (k = nsc_pkg::TAG_COUNT - 1; k >= 0; k--) begin
                    if (sm_mask[k]) begin
                        kind = 4'(nsc_pkg::KIND_TAG_BASE + k);
                    end
                end
            end
        end
        res = {kind, sm_xor, sm_star ? sm_hex : 8'h00};
        sentence_clear();
        return 1'b1;
    endfunction

    // Idle length for either side: usually none or short, now and then long.
    function automatic int unsigned pick_idle(input bit calm);
        int unsigned r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit lower);
        if (nib < 4'd10) begin
            return 8'h30 + 8'(nib);
        end
        return (lower ? 8'h61 : 8'h41) + 8'(nib) - 8'd10;
    endfunction

    // Offers one byte request and returns at the edge where it is accepted. Valid is
    // lowered only when a gap follows, so a back-to-back request keeps it high.
    task automatic send_byte(input logic [7:0] ch, input logic lst, input bit typed_in,
                             input nsc_pkg::t_out want);
        int unsigned   gap;
        nsc_pkg::t_out pred;
        gap = pick_idle(src_calm);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{byte_req: ch, last: lst};
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        if (classify_byte(ch, lst, pred)) begin
            expected_kinds_q.push_back(typed_in ? want : pred);
        end
    endtask

    // Builds one random sentence and sends it. Most are well formed with random
    // content; the rest are cut short or are plain noise bytes.
    task automatic send_random_sentence();
        logic [7:0]    line_q [$];
        logic [7:0]    sum;
        logic [7:0]    ch;
        nsc_pkg::t_out no_result;
        int unsigned   form;
        int unsigned   k;
        int unsigned   n;
        int unsigned   tag_len;
        int unsigned   cut;
        bit            lower;
        no_result = '0;
        form  = $urandom_range(0, 99);
        lower = 1'($urandom_range(0, 1));
        if (form >= 88) begin
            // Noise: any byte value, asterisks and hex digits included by chance.
            n = $urandom_range(1, 20);
            repeat (n) line_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            line_q.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : "$");
            k = $urandom_range(0, nsc_pkg::TAG_COUNT - 1);
            tag_len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 4)
                                                   : nsc_pkg::TAG_LEN;
            for (int i = 0; i < tag_len; i++) begin
                line_q.push_back(nsc_pkg::TAG_TABLE[k][i]);
            end
            // Now and then one tag letter is replaced by a random capital, so the tag may match no row.
            if (tag_len != 0 && $urandom_range(0, 9) == 0) begin
                line_q[$urandom_range(1, tag_len)] = 8'($urandom_range(8'h41, 8'h5A));
            end
            n = $urandom_range(0, 10);
            repeat (n) begin
                do begin
                    ch = 8'($urandom_range(8'h20, 8'h7E));
                end while (ch == nsc_pkg::STAR_CHAR);
                line_q.push_back(ch);
            end
            sum = 8'h00;
            for (int i = 1; i < line_q.size(); i++) begin
                sum ^= line_q[i];
            end
            if ($urandom_range(0, 99) < 90) begin
                line_q.push_back(nsc_pkg::STAR_CHAR);
                if ($urandom_range(0, 9) == 0) begin
                    sum ^= 8'($urandom_range(1, 255));
                end
                // Extra leading digits shift out of the low byte and leave it intact.
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
                repeat (n) line_q.push_back(hex_char(4'($urandom),
                                                     1'($urandom_range(0, 1))));
                line_q.push_back(hex_char(sum[7:4], lower));
                line_q.push_back(hex_char(sum[3:0], lower));
            end
            if ($urandom_range(0, 4) == 0) begin
                line_q.push_back(8'h0D);
                line_q.push_back(8'h0A);
            end
            if (form >= 75) begin
                // Cut short: last may land in the body, on the asterisk or in the digits.
                cut = $urandom_range(1, line_q.size());
                while (line_q.size() > cut) begin
                    line_q.delete(line_q.size() - 1);
                end
            end
        end
        for (int i = 0; i < line_q.size(); i++) begin
            send_byte(line_q[i], i == line_q.size() - 1, 1'b0, no_result);
        end
        random_items += line_q.size();
    endtask

    // Holds the sender until every expected result has come, then lets the
    // pipeline settle. Valid is dropped first so the last request is not
    // offered again while the sender waits.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (expected_kinds_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    // Consumer side. Ready goes low for random stretches, stays high while
    // sink_calm is set, and is held low for a long hold-off when one is asked for.
    int unsigned sink_wait = 0;
    int unsigned sink_run  = 0;
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            sink_wait = 0;
            sink_run  = 0;
        end else begin
            if (hold_pending) begin
                hold_pending = 1'b0;
                sink_wait = HOLD_CYCLES;
            end
            if (sink_wait != 0) begin
                sink_wait--;
                out_ready <= 1'b0;
            end else if (sink_calm || sink_run != 0) begin
                if (sink_run != 0) begin
                    sink_run--;
                end
                out_ready <= 1'b1;
            end else begin
                sink_wait = pick_idle(1'b0);
                sink_run  = $urandom_range(1, 8);
                if (sink_wait != 0) begin
                    sink_wait--;
                    out_ready <= 1'b0;
                end else begin
                    out_ready <= 1'b1;
                end
            end
        end
    end

    // Result checker: every accepted result must match the oldest expectation.
    always @(posedge clk) begin
        nsc_pkg::t_out exp_res;
        if (rst_n && out_valid && out_ready) begin
            if (expected_kinds_q.size() == 0) begin
                $error("result with no request pending: kind %0d sums %02h/%02h",
                       out_data.sentence_kind, out_data.computed_sum,
                       out_data.received_sum);
                fail_count++;
            end else begin
                exp_res = expected_kinds_q.pop_front();
                if (out_data.sentence_kind !== exp_res.sentence_kind) begin
                    $error("sentence_kind: expected %0d, got %0d",
                           exp_res.sentence_kind, out_data.sentence_kind);
                    fail_count++;
                end
                if (out_data.computed_sum !== exp_res.computed_sum) begin
                    $error("computed_sum: expected %02h, got %02h",
                           exp_res.computed_sum, out_data.computed_sum);
                    fail_count++;
                end
                if (out_data.received_sum !== exp_res.received_sum) begin
                    $error("received_sum: expected %02h, got %02h",
                           exp_res.received_sum, out_data.received_sum);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus thread.
    initial begin
        // Directed sentences. Typed-in results are the ones that can be read off
        // directly: a lone start mark, a sentence with no asterisk, and a checksum
        // error whose long digit run keeps only its low byte.
        dir_rows = '{
            '{"$", 1'b1, 1'b1, {nsc_pkg::KIND_UNKNOWN, 8'h00, 8'h00}},
            // A well-formed GGA sentence with a correct checksum.
            '{"$", 1'b0, 1'b0, '0},
            '{"G", 1'b0, 1'b0, '0},
            '{"P", 1'b0, 1'b0, '0},
            '{"G", 1'b0, 1'b0, '0},
            '{"G", 1'b0, 1'b0, '0},
            '{"A", 1'b0, 1'b0, '0},
            '{"*", 1'b0, 1'b0, '0},
            '{"5", 1'b0, 1'b0, '0},
            '{"6", 1'b1, 1'b0, '0},
            // No asterisk at all.
            '{"!", 1'b0, 1'b0, '0},
            '{"A", 1'b0, 1'b0, '0},
            '{"B", 1'b1, 1'b1, {nsc_pkg::KIND_UNKNOWN, 8'h03, 8'h00}},
            // Sums differ; three digits, one of them a lower case letter.
            '{"$", 1'b0, 1'b0, '0},
            '{"A", 1'b0, 1'b0, '0},
            '{"*", 1'b0, 1'b0, '0},
            '{"1", 1'b0, 1'b0, '0},
            '{"a", 1'b0, 1'b0, '0},
            '{"1", 1'b1, 1'b1, {nsc_pkg::KIND_CSUM_ERR, 8'h41, 8'hA1}},
            // Extreme byte values, then a second asterisk that must be ignored.
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0},
            '{"*", 1'b0, 1'b0, '0},
            '{"f", 1'b0, 1'b0, '0},
            '{"F", 1'b0, 1'b0, '0},
            '{"*", 1'b0, 1'b0, '0},
            '{"*", 1'b1, 1'b0, '0}
        };

        sentence_clear();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            send_byte(dir_rows[r].ch, dir_rows[r].lst, dir_rows[r].typed_in,
                      dir_rows[r].want);
        end
        // Sender pause: nothing new until the directed results are all in.
        wait_for_results();

        while (random_items < RANDOM_ITEMS * 3 / 10) begin
            send_random_sentence();
        end

        // Long consumer hold-off while the sender keeps pushing requests with no
        // gaps, so both pipeline stages fill and ready drops at the input.
        hold_pending = 1'b1;
        src_calm = 1'b1;
        repeat (4) send_random_sentence();
        src_calm = 1'b0;
        wait_for_results();

        // A stretch with no idling on either side.
        src_calm  = 1'b1;
        sink_calm = 1'b1;
        while (random_items < RANDOM_ITEMS / 2) begin
            send_random_sentence();
        end
        src_calm  = 1'b0;
        sink_calm = 1'b0;

        while (random_items < RANDOM_ITEMS) begin
            send_random_sentence();
        end

        wait_for_results();
        if (fail_count == 0) begin
            $display("nmea_sentence_classifier regression: pass");
        end else begin
            $display("nmea_sentence_classifier regression: fail");
        end
        $finish;
    end

endmodule
